/* hdl/poly_derivative_eval_core_defines.svh */
`ifndef POLY_DERIVATIVE_EVAL_CORE_DEFINES_SVH
`define POLY_DERIVATIVE_EVAL_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PDE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PDE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pde_pkg.sv */
`timescale 1ns / 1ps

package pde_pkg;

    localparam int DATA_W = 32;
    localparam int EVAL_W = 16;

    // queue entry: coefficient, kind and last flag around the exponent field
    localparam int ENTRY_FIXED_W = DATA_W + 2;

    typedef enum logic {
        TERM_SKIP,
        TERM_POWER
    } term_kind_t;

    typedef struct packed {
        logic busy;
        logic acc_stage;
    } back_status_t;

endpackage

/* hdl/pde_if.sv */
`timescale 1ns / 1ps

interface pde_term_if #(
    parameter int EXP_BITS = 6
);
    logic                             valid;
    logic                             ready;
    logic signed [pde_pkg::DATA_W-1:0] coefficient;
    logic [EXP_BITS-1:0]              exponent;
    logic                             last_term;

    modport source (output valid, coefficient, exponent, last_term, input ready);
    modport sink   (input valid, coefficient, exponent, last_term, output ready);
endinterface

interface pde_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [pde_pkg::DATA_W-1:0] derivative_value;

    modport source (output valid, derivative_value, input ready);
    modport sink   (input valid, derivative_value, output ready);
endinterface

/* hdl/pde_front.sv */
`timescale 1ns / 1ps

module pde_front #(
    parameter int EXP_BITS = 6
) (
    pde_term_if.sink                                        term,
    input  logic                                            q_ready,
    output logic                                            push,
    output logic [pde_pkg::ENTRY_FIXED_W+EXP_BITS-1:0]      push_data
);

    typedef struct packed {
        logic [pde_pkg::DATA_W-1:0] coef;
        logic [EXP_BITS-1:0]        exp_m1;
        pde_pkg::term_kind_t        kind;
        logic                       last;
    } entry_t;

    entry_t entry;

    always_comb
    begin
        entry.coef   = term.coefficient;
        entry.exp_m1 = term.exponent - EXP_BITS'(1);
        entry.kind   = (term.exponent == '0) ? pde_pkg::TERM_SKIP : pde_pkg::TERM_POWER;
        entry.last   = term.last_term;
    end

    assign term.ready = q_ready;
    assign push       = term.valid && q_ready;
    assign push_data  = entry;

endmodule

/* hdl/pde_queue.sv */
`timescale 1ns / 1ps

module pde_queue #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             q_ready,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] q_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign q_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];

endmodule

/* hdl/pde_back.sv */
`timescale 1ns / 1ps

module pde_back #(
    parameter int EXP_BITS = 6
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [pde_pkg::EVAL_W-1:0]                  eval_point,
    input  logic                                        q_valid,
    input  logic [pde_pkg::ENTRY_FIXED_W+EXP_BITS-1:0]  q_data,
    output logic                                        pop,
    output pde_pkg::back_status_t                       status,
    pde_result_if.source                                result
);

    localparam int DW = pde_pkg::DATA_W;

    typedef struct packed {
        logic [DW-1:0]       coef;
        logic [EXP_BITS-1:0] exp_m1;
        pde_pkg::term_kind_t kind;
        logic                last;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POW,
        S_MUL,
        S_ACC
    } state_t;

    state_t              state_reg, state_next;
    logic [DW-1:0]       base_reg, base_next;
    logic [DW-1:0]       acc_reg, acc_next;
    logic [EXP_BITS-1:0] e_reg, e_next;
    logic [DW-1:0]       cm_reg, cm_next;
    logic [DW-1:0]       term_reg, term_next;
    logic                last_reg, last_next;
    logic [DW-1:0]       sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    logic [DW-1:0]       out_data_reg, out_data_next;

    entry_t              head;
    logic [DW-1:0]       x_ext;
    logic [EXP_BITS-1:0] exp_full;
    logic [DW-1:0]       coef_exp;
    logic [DW-1:0]       mul_b;
    logic [DW-1:0]       prod_ab;
    logic [DW-1:0]       prod_bb;
    logic [DW-1:0]       sum_add;

    assign head     = entry_t'(q_data);
    assign x_ext    = {{(DW - pde_pkg::EVAL_W){eval_point[pde_pkg::EVAL_W-1]}}, eval_point};
    assign exp_full = head.exp_m1 + EXP_BITS'(1);
    assign coef_exp = head.coef * {{(DW - EXP_BITS){1'b0}}, exp_full};
    assign mul_b    = (state_reg == S_MUL) ? cm_reg : base_reg;
    assign prod_ab  = acc_reg * mul_b;
    assign prod_bb  = base_reg * base_reg;
    assign sum_add  = sum_reg + term_reg;

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        cm_next        = cm_reg;
        term_next      = term_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    last_next = head.last;
                    if (head.kind == pde_pkg::TERM_SKIP)
                    begin
                        term_next  = '0;
                        state_next = S_ACC;
                    end
                    else
                    begin
                        base_next  = x_ext;
                        acc_next   = DW'(1);
                        e_next     = head.exp_m1;
                        cm_next    = coef_exp;
                        state_next = (head.exp_m1 == '0) ? S_MUL : S_POW;
                    end
                end
            end
            S_POW:
            begin
                if (e_reg[0])
                begin
                    acc_next = prod_ab;
                end
                base_next = prod_bb;
                e_next    = e_reg >> 1;
                if ((e_reg >> 1) == '0)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                term_next  = prod_ab;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (!last_reg)
                begin
                    sum_next   = sum_add;
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = sum_add;
                    sum_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            acc_reg       <= '0;
            e_reg         <= '0;
            cm_reg        <= '0;
            term_reg      <= '0;
            last_reg      <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            acc_reg       <= acc_next;
            e_reg         <= e_next;
            cm_reg        <= cm_next;
            term_reg      <= term_next;
            last_reg      <= last_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign status.busy      = (state_reg != S_IDLE);
    assign status.acc_stage = (state_reg == S_ACC);

    assign result.valid            = out_valid_reg;
    assign result.derivative_value = out_data_reg;

endmodule

/* hdl/poly_derivative_eval_core.sv */
// The back end takes one queue entry at a time: a square-and-multiply loop (one exponent bit per
// cycle, squaring on its own multiplier, the other multiplier shared with the coefficient
// step), then the coefficient multiply, then accumulate, which a stalled result can hold.
// A queue (two entries by default) lets requests be taken while the back end is busy.
// Reset (rst_n low, asynchronous) clears the sum, eval point, queue and result.
`timescale 1ns / 1ps
`include "poly_derivative_eval_core_defines.svh"

module poly_derivative_eval_core #(
    parameter int EXP_BITS    = 6,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic [pde_pkg::EVAL_W-1:0]  cfg_wdata,
    pde_term_if.sink                    term,
    pde_result_if.source                result
);

    localparam int ENTRY_W = pde_pkg::ENTRY_FIXED_W + EXP_BITS;

    logic [pde_pkg::EVAL_W-1:0] eval_point_reg;
    logic                       push;
    logic [ENTRY_W-1:0]         push_data;
    logic                       q_ready;
    logic                       q_valid;
    logic [ENTRY_W-1:0]         q_data;
    logic                       q_pop;
    pde_pkg::back_status_t      back_st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_point_reg <= '0;
        end
        else if (cfg_wen)
        begin
            eval_point_reg <= cfg_wdata;
        end
    end

    pde_front #(
        .EXP_BITS (EXP_BITS)
    ) u_front (
        .term      (term),
        .q_ready   (q_ready),
        .push      (push),
        .push_data (push_data)
    );

    pde_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    pde_back #(
        .EXP_BITS (EXP_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .eval_point (eval_point_reg),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (q_pop),
        .status     (back_st),
        .result     (result)
    );

    `PDE_ASSERT_NOW(a_pop_needs_entry, q_pop, q_valid, "pop from empty queue")
    `PDE_ASSERT_NOW(a_full_idle_drains, !term.ready && !back_st.busy, q_pop, "idle back end left queue full")
    `PDE_ASSERT_NOW(a_result_from_acc, $rose(result.valid), $past(back_st.acc_stage), "result raised outside accumulate")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int EXP_BITS     = 6;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE_WAIT  = EXP_BITS + 6;
    localparam int TAIL_WAIT    = 20;
    localparam int CHOKE_CYCLES = 400;
    localparam int PHASE_TERMS  = 170;

    class derivative_tracker;
        logic [31:0] point;
        logic [31:0] partial_sum;
        logic [31:0] pending[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            point       = '0;
            partial_sum = '0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void set_point(logic [pde_pkg::EVAL_W-1:0] x);
            point = {{(32 - pde_pkg::EVAL_W){x[pde_pkg::EVAL_W-1]}}, x};
        endfunction

        function void note_term(logic [31:0] coef, logic [EXP_BITS-1:0] expo, bit last);
            logic [31:0] pw;
            logic [31:0] mult;
            int i;
            pw   = 32'd1;
            mult = {{(32 - EXP_BITS){1'b0}}, expo};
            for (i = 1; i < int'(expo); i++)
                pw = pw * point;
            if (expo != 0)
                partial_sum = partial_sum + coef * mult * pw;
            if (last)
            begin
                pending.push_back(partial_sum);
                partial_sum = '0;
            end
        endfunction

        function void check_derivative(logic [31:0] actual);
            logic [31:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: derivative %0d arrived with none pending", $time,
                         $signed(actual));
                mismatches++;
            end
            else
            begin
                want = pending.pop_front();
                checked++;
                if (actual !== want)
                begin
                    $display("%0t: derivative expected %0d actual %0d", $time,
                             $signed(want), $signed(actual));
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wen;
    logic [pde_pkg::EVAL_W-1:0] cfg_wdata;

    pde_term_if #(.EXP_BITS(EXP_BITS)) term_ch ();
    pde_result_if                      result_ch ();

    poly_derivative_eval_core #(.EXP_BITS(EXP_BITS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .term      (term_ch),
        .result    (result_ch)
    );

    derivative_tracker tracker;
    bit quiet;
    bit choke_request;
    int terms_sent;
    int polys_sent;
    int points_used;

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_term(input logic [31:0] coef, input logic [EXP_BITS-1:0] expo,
                             input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            term_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        term_ch.valid       <= 1'b1;
        term_ch.coefficient <= coef;
        term_ch.exponent    <= expo;
        term_ch.last_term   <= last;
        do
            @(posedge clk);
        while (!(term_ch.valid && term_ch.ready));
        tracker.note_term(coef, expo, last);
        terms_sent++;
        if (last)
            polys_sent++;
    endtask

    // drop valid and hold until every derivative is back and the core has settled
    task automatic drain();
        term_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_eval_point(input logic [pde_pkg::EVAL_W-1:0] x);
        cfg_wen   <= 1'b1;
        cfg_wdata <= x;
        @(posedge clk);
        cfg_wen <= 1'b0;
        tracker.set_point(x);
        points_used++;
    endtask

    task automatic send_polynomial(input int n_terms);
        logic [31:0] coef;
        logic [EXP_BITS-1:0] expo;
        int i;
        for (i = 0; i < n_terms; i++)
        begin
            case ($urandom_range(0, 3))
                0:       coef = $urandom_range(0, 20) - 10;
                default: coef = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       expo = EXP_BITS'($urandom_range(0, 3));
                1:       expo = {EXP_BITS{1'b1}};
                default: expo = EXP_BITS'($urandom_range(0, (1 << EXP_BITS) - 1));
            endcase
            send_term(coef, expo, i == n_terms - 1);
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 6);
        if (r < 95)
            return $urandom_range(7, 16);
        return $urandom_range(17, 40);
    endfunction

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                tracker.check_derivative(result_ch.derivative_value);
            if (choke_request)
            begin
                stall_left    = CHOKE_CYCLES;
                choke_request = 1'b0;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 2) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (term_ch.valid && term_ch.ready)
                    || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int point_plan[10];
        int phase;
        int phase_start;
        tracker       = new();
        quiet         = 1'b0;
        choke_request = 1'b0;
        terms_sent    = 0;
        polys_sent    = 0;
        points_used   = 0;
        rst_n               <= 1'b0;
        cfg_wen             <= 1'b0;
        cfg_wdata           <= '0;
        term_ch.valid       <= 1'b0;
        term_ch.coefficient <= '0;
        term_ch.exponent    <= '0;
        term_ch.last_term   <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // x at its reset value of zero: only first-power terms count
        send_term(32'd5, 6'd1, 1'b1);
        send_term(32'h7fffffff, 6'd0, 1'b0);
        send_term(32'h80000000, 6'd1, 1'b1);
        send_term(32'd9, 6'd2, 1'b0);
        send_term(32'hfffffffd, 6'd63, 1'b1);
        drain();
        write_eval_point(16'sd3);
        send_term(32'd7, 6'd63, 1'b0);
        send_term(32'hffffffff, 6'd2, 1'b0);
        send_term(32'h7fffffff, 6'd5, 1'b1);
        drain();
        write_eval_point(16'h8000);
        send_term(32'h80000000, 6'd63, 1'b1);
        send_term(32'd1, 6'd62, 1'b0);
        send_term(32'hffffffff, 6'd1, 1'b1);
        drain();
        write_eval_point(16'h7fff);
        send_term(32'h7fffffff, 6'd63, 1'b0);
        send_term(32'hffffffff, 6'd32, 1'b0);
        send_term(32'd0, 6'd17, 1'b1);
        drain();
        write_eval_point(16'hffff);
        send_term(32'd1, 6'd63, 1'b0);
        send_term(32'd1, 6'd62, 1'b1);
        drain();

        point_plan = '{1, -1, 32767, -32768, 2, $urandom_range(0, 65535),
                       $urandom_range(0, 65535), -3, $urandom_range(0, 65535), 0};
        for (phase = 0; phase < 10; phase++)
        begin
            write_eval_point(point_plan[phase][15:0]);
            quiet = (phase == 4);
            if (phase == 6)
                choke_request = 1'b1;
            phase_start = terms_sent;
            while (terms_sent - phase_start < PHASE_TERMS)
                send_polynomial(pick_length());
            drain();
        end
        quiet = 1'b0;

        term_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Sent %0d terms in %0d polynomials over %0d evaluation points;",
                 terms_sent, polys_sent, points_used);
        $display("checked %0d derivatives, including a long result-side stall.",
                 tracker.checked);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
